@@ sv/irb_pkg.sv @@
// ----------------------------------------------------------------------------
// irb_pkg: shared constants for the bilinear / nearest image resizer
// Default sizes, field widths and request codes.
// ----------------------------------------------------------------------------
package irb_pkg;

    localparam int MAX_WIDTH_DEF    = 256;
    localparam int MAX_HEIGHT_DEF   = 256;
    localparam int MAX_CHANNELS_DEF = 3;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int CFG_W  = 9;   // size register width
    localparam int CIDX_W = 3;   // config index width
    localparam int NUM_W  = 19;  // signed (2d+1)*S - D
    localparam int DEN_W  = 10;  // 2*D

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    localparam logic [CIDX_W-1:0] REG_SRC_W  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_SRC_H  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TGT_W  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_TGT_H  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_CHAN   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_MODE   = 3'd5;

    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

endpackage

@@ sv/image_resize_bilinear_nearest_top.sv @@
// ----------------------------------------------------------------------------
// image_resize_bilinear_nearest_top: image resizer with frame store
// Loads fill a single-port frame store; computes return one resized sample.
// A load gives no beat. A compute result waits on the bit-serial coordinate
// divider, run once per axis, and on the single-port frame store reads: four
// in bilinear mode, one in nearest mode. A range error skips both.
// Throughput: one compute at a time, the next beat taken the cycle after the
// result is registered; loads are taken every cycle when idle.
// Reset returns the sequencer to idle and the registers to their defaults;
// the frame store is undefined until written.
// ----------------------------------------------------------------------------
module image_resize_bilinear_nearest_top #(
    parameter int MAX_WIDTH    = irb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = irb_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_CHANNELS = irb_pkg::MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = irb_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // config write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [irb_pkg::CIDX_W-1:0] cfg_index,
    input  logic [irb_pkg::CFG_W-1:0]  cfg_data,
    // request stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // col[7:0], row[15:8], chan[17:16], sample_in[25:18]
    input  logic                       s_tuser,   // req_type[0]
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // sample_out[7:0], out_col[15:8], out_row[23:16], out_chan[25:24]
    output logic                       m_tuser    // range_error[0]
);
    localparam int CW    = irb_pkg::CFG_W;
    localparam int PW    = irb_pkg::NUM_W + FRAC_BITS;
    localparam int IW    = irb_pkg::NUM_W;          // integer part of p
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = FRAC_BITS + 1;            // weight width
    localparam int HW    = FRAC_BITS + 10;           // row blend width
    localparam int ACCW  = 2 * FRAC_BITS + 12;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DXGO = 4'd1;
    localparam logic [3:0] ST_DX   = 4'd2;
    localparam logic [3:0] ST_DYGO = 4'd3;
    localparam logic [3:0] ST_DY   = 4'd4;
    localparam logic [3:0] ST_ADDR = 4'd5;
    localparam logic [3:0] ST_RD   = 4'd6;
    localparam logic [3:0] ST_WAIT = 4'd7;
    localparam logic [3:0] ST_MUL1 = 4'd8;
    localparam logic [3:0] ST_MUL2 = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0] src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    logic [1:0]    chan_cnt_reg;
    logic          mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg    <= CW'(256);
            src_h_reg    <= CW'(256);
            tgt_w_reg    <= CW'(256);
            tgt_h_reg    <= CW'(256);
            chan_cnt_reg <= 2'd3;
            mode_reg     <= irb_pkg::MODE_BILINEAR;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                irb_pkg::REG_SRC_W: src_w_reg    <= cfg_data;
                irb_pkg::REG_SRC_H: src_h_reg    <= cfg_data;
                irb_pkg::REG_TGT_W: tgt_w_reg    <= cfg_data;
                irb_pkg::REG_TGT_H: tgt_h_reg    <= cfg_data;
                irb_pkg::REG_CHAN:  chan_cnt_reg <= cfg_data[1:0];
                irb_pkg::REG_MODE:  mode_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, sources saturate at the store size.
    logic [CW-1:0] sw, sh, tw, th;
    logic [1:0]    cc;

    assign sw = (src_w_reg == '0) ? CW'(1)
              : ((32'(src_w_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : src_w_reg);
    assign sh = (src_h_reg == '0) ? CW'(1)
              : ((32'(src_h_reg) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : src_h_reg);
    assign tw = (tgt_w_reg == '0) ? CW'(1) : tgt_w_reg;
    assign th = (tgt_h_reg == '0) ? CW'(1) : tgt_h_reg;
    assign cc = (chan_cnt_reg == '0) ? 2'd1
              : ((32'(chan_cnt_reg) > MAX_CHANNELS) ? 2'(MAX_CHANNELS) : chan_cnt_reg);

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    logic [7:0] in_col, in_row, in_smp;
    logic [1:0] in_chan;

    assign in_col  = s_tdata[7:0];
    assign in_row  = s_tdata[15:8];
    assign in_chan = s_tdata[17:16];
    assign in_smp  = s_tdata[25:18];

    logic [3:0]  state_reg;
    logic [7:0]  col_reg, row_reg;
    logic [1:0]  chan_reg;
    logic        err_reg;
    logic signed [PW-1:0] px_reg, py_reg;

    logic in_beat;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Coordinate mapping: p = ((2d+1)*S - D) * 2^F / (2D), floored
    // ------------------------------------------------------------------
    logic                          div_start, div_done;
    logic signed [irb_pkg::NUM_W-1:0] div_num;
    logic [irb_pkg::DEN_W-1:0]     div_den;
    logic signed [PW-1:0]          div_q;
    logic                          on_y;
    logic [CW-1:0]                 d_odd, s_sel, t_sel;
    logic [2*CW-1:0]               prod;

    assign on_y      = (state_reg == ST_DYGO);
    assign div_start = (state_reg == ST_DXGO) || on_y;
    assign d_odd     = on_y ? {row_reg, 1'b1} : {col_reg, 1'b1};
    assign s_sel     = on_y ? sh : sw;
    assign t_sel     = on_y ? th : tw;
    assign prod      = d_odd * s_sel;
    assign div_num   = $signed({1'b0, prod[irb_pkg::NUM_W-2:0]})
                     - $signed({{(irb_pkg::NUM_W-CW){1'b0}}, t_sel});
    assign div_den   = {t_sel, 1'b0};

    irb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // ------------------------------------------------------------------
    // Source indexes and weights
    // ------------------------------------------------------------------
    logic signed [IW-1:0] lx, ly, nx, ny;
    logic signed [PW-1:0] rx, ry;
    logic [FRAC_BITS-1:0] fxc, fyc;

    assign lx  = IW'(px_reg >>> FRAC_BITS);
    assign ly  = IW'(py_reg >>> FRAC_BITS);
    assign fxc = px_reg[FRAC_BITS-1:0];
    assign fyc = py_reg[FRAC_BITS-1:0];
    assign rx  = (px_reg + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign ry  = (py_reg + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign nx  = px_reg[PW-1] ? '0 : IW'(rx);
    assign ny  = py_reg[PW-1] ? '0 : IW'(ry);

    function automatic logic [CW-1:0] clamp_idx(input logic signed [IW-1:0] v,
                                                 input logic [CW-1:0] size);
        logic signed [IW-1:0] top;
        top = $signed({{(IW-CW){1'b0}}, size}) - IW'(1);
        if (v < 0)
            return '0;
        else if (v > top)
            return CW'(top);
        else
            return CW'(v);
    endfunction

    logic [XW-1:0] x0_reg, x1_reg;
    logic [YW-1:0] y0_reg, y1_reg;
    logic [WW-1:0] fx_reg, gx_reg, fy_reg, gy_reg;
    logic          one_rd_reg;

    // ------------------------------------------------------------------
    // Frame store: single port, registered read
    // ------------------------------------------------------------------
    logic [7:0]    store [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [1:0]    rd_cnt_reg;
    logic [1:0]    rd_tag_reg;
    logic          rd_live_reg;
    logic          st_we, st_re;
    logic [AW-1:0] st_addr;
    logic [XW-1:0] ax;
    logic [YW-1:0] ay;
    logic [1:0]    ac;

    always_comb
    begin
        ax = XW'(in_col);
        ay = YW'(in_row);
        ac = in_chan;
        if (state_reg == ST_RD)
        begin
            ax = rd_cnt_reg[0] ? x1_reg : x0_reg;
            ay = rd_cnt_reg[1] ? y1_reg : y0_reg;
            ac = chan_reg;
        end
    end

    assign st_addr = AW'((((AW+2)'(ay) * (AW+2)'(MAX_WIDTH)) + (AW+2)'(ax))
                         * (AW+2)'(MAX_CHANNELS) + (AW+2)'(ac));
    assign st_we   = in_beat && (s_tuser == irb_pkg::REQ_LOAD)
                   && (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT)
                   && (32'(in_chan) < MAX_CHANNELS);
    assign st_re   = (state_reg == ST_RD);

    always_ff @(posedge clk)
    begin
        if (st_we)
            store[st_addr] <= in_smp;
        if (st_re)
            rd_data_reg <= store[st_addr];
    end

    // ------------------------------------------------------------------
    // Blend datapath
    // ------------------------------------------------------------------
    logic [7:0]      v_reg [4];
    logic [HW-1:0]   h0_reg, h1_reg;
    logic [ACCW-1:0] acc_reg;
    logic [ACCW-1:0] acc_rnd;
    logic [7:0]      smp_fin;

    assign acc_rnd = (acc_reg + (ACCW'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
    assign smp_fin = (acc_rnd > ACCW'(255)) ? 8'd255 : acc_rnd[7:0];

    // ------------------------------------------------------------------
    // Result register: holds the beat while the request side moves on
    // ------------------------------------------------------------------
    logic       out_valid_reg;
    logic [7:0] out_smp_reg;
    logic [7:0] out_col_reg, out_row_reg;
    logic [1:0] out_chan_reg;
    logic       out_err_reg;
    logic       fin;

    assign fin = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_chan_reg, out_row_reg, out_col_reg, out_smp_reg};
    assign m_tuser  = out_err_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            rd_live_reg   <= 1'b0;
        end
        else
        begin
            rd_live_reg   <= st_re;
            out_valid_reg <= fin || (out_valid_reg && !m_tready);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat && (s_tuser == irb_pkg::REQ_COMPUTE))
                    begin
                        if ((CW'(in_col) >= tw) || (CW'(in_row) >= th) || (in_chan >= cc))
                            state_reg <= ST_DONE;
                        else
                            state_reg <= ST_DXGO;
                    end
                end
                ST_DXGO: state_reg <= ST_DX;
                ST_DX:   if (div_done) state_reg <= ST_DYGO;
                ST_DYGO: state_reg <= ST_DY;
                ST_DY:   if (div_done) state_reg <= ST_ADDR;
                ST_ADDR:
                begin
                    rd_cnt_reg <= '0;
                    state_reg  <= ST_RD;
                end
                ST_RD:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (one_rd_reg || (rd_cnt_reg == 2'd3))
                        state_reg <= ST_WAIT;
                end
                ST_WAIT: state_reg <= ST_MUL1;
                ST_MUL1: state_reg <= ST_MUL2;
                ST_MUL2: state_reg <= ST_DONE;
                ST_DONE: if (fin) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_tag_reg <= rd_cnt_reg;
        if (in_beat)
        begin
            col_reg  <= in_col;
            row_reg  <= in_row;
            chan_reg <= in_chan;
            err_reg  <= (CW'(in_col) >= tw) || (CW'(in_row) >= th) || (in_chan >= cc);
            acc_reg  <= '0;
        end
        if ((state_reg == ST_DX) && div_done)
            px_reg <= div_q;
        if ((state_reg == ST_DY) && div_done)
            py_reg <= div_q;
        if (state_reg == ST_ADDR)
        begin
            // Nearest: one read at the rounded point with full weight.
            one_rd_reg <= (mode_reg == irb_pkg::MODE_NEAREST);
            for (int k = 0; k < 4; k++)
                v_reg[k] <= '0;
            if (mode_reg == irb_pkg::MODE_NEAREST)
            begin
                x0_reg <= XW'(clamp_idx(nx, sw));
                y0_reg <= YW'(clamp_idx(ny, sh));
                x1_reg <= XW'(clamp_idx(nx, sw));
                y1_reg <= YW'(clamp_idx(ny, sh));
                fx_reg <= '0;
                fy_reg <= '0;
                gx_reg <= WW'(1) << FRAC_BITS;
                gy_reg <= WW'(1) << FRAC_BITS;
            end
            else
            begin
                x0_reg <= XW'(clamp_idx(lx, sw));
                x1_reg <= XW'(clamp_idx(lx + IW'(1), sw));
                y0_reg <= YW'(clamp_idx(ly, sh));
                y1_reg <= YW'(clamp_idx(ly + IW'(1), sh));
                fx_reg <= WW'(fxc);
                fy_reg <= WW'(fyc);
                gx_reg <= (WW'(1) << FRAC_BITS) - WW'(fxc);
                gy_reg <= (WW'(1) << FRAC_BITS) - WW'(fyc);
            end
        end
        if (rd_live_reg)
            v_reg[rd_tag_reg] <= rd_data_reg;
        if (state_reg == ST_MUL1)
        begin
            h0_reg <= HW'(v_reg[0]) * HW'(gx_reg) + HW'(v_reg[1]) * HW'(fx_reg);
            h1_reg <= HW'(v_reg[2]) * HW'(gx_reg) + HW'(v_reg[3]) * HW'(fx_reg);
        end
        if (state_reg == ST_MUL2)
            acc_reg <= ACCW'(h0_reg) * ACCW'(gy_reg) + ACCW'(h1_reg) * ACCW'(fy_reg);
        if (fin)
        begin
            out_smp_reg  <= err_reg ? 8'd0 : smp_fin;
            out_col_reg  <= col_reg;
            out_row_reg  <= row_reg;
            out_chan_reg <= chan_reg;
            out_err_reg  <= err_reg;
        end
    end

endmodule

@@ sv/irb_div.sv @@
// ----------------------------------------------------------------------------
// irb_div: coordinate divider
// Floor of num * 2^FRAC_BITS / den, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module irb_div #(
    parameter int FRAC_BITS = irb_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [irb_pkg::NUM_W-1:0]       num,
    input  logic        [irb_pkg::DEN_W-1:0]       den,
    output logic                                   done,
    output logic signed [irb_pkg::NUM_W+FRAC_BITS-1:0] quot
);
    localparam int MW  = irb_pkg::NUM_W - 1;
    localparam int QW  = MW + FRAC_BITS;
    localparam int CW  = $clog2(QW + 1);
    localparam int DW  = irb_pkg::DEN_W;

    logic [QW-1:0]                q_reg;
    logic [DW-1:0]                rem_reg;
    logic [DW-1:0]                den_reg;
    logic                         neg_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [DW:0]                  rem_sh;
    logic                         qbit;
    logic [MW-1:0]                mag;

    assign mag    = num[irb_pkg::NUM_W-1] ? MW'(-num) : num[MW-1:0];
    assign rem_sh = {rem_reg, q_reg[QW-1]};
    assign qbit   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= {mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[irb_pkg::NUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? DW'(rem_sh - {1'b0, den_reg})
                            : rem_sh[DW-1:0];
            q_reg   <= {q_reg[QW-2:0], qbit};
        end
    end

    // Floor toward minus infinity for negative numerators.
    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, q_reg}) - $signed({{QW{1'b0}}, (rem_reg != '0)})
                          : $signed({1'b0, q_reg});

endmodule

@@ sv/irb_checker.sv @@
// ----------------------------------------------------------------------------
// irb_checker: port-level checks for the image resizer
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module irb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);
    // Hold a stalled result beat.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A flagged request carries a zero sample.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0)
        else $error("range error with nonzero sample");

    // A compute beat occupies the block for at least the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("request taken while compute in flight");

endmodule

bind image_resize_bilinear_nearest_top irb_checker u_irb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ verif/image_resize_bilinear_nearest_top_test.sv @@
// ----------------------------------------------------------------------------
// image_resize_bilinear_nearest_top_test: self-checking bench for the resizer
// Fills the frame store over the request stream, then asks for resized samples
// under several size and mode settings. Each sample is checked against an
// in-bench resampler. Both streams idle at random.
// ----------------------------------------------------------------------------
module image_resize_bilinear_nearest_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MW = irb_pkg::MAX_WIDTH_DEF;
    localparam int MH = irb_pkg::MAX_HEIGHT_DEF;
    localparam int MC = irb_pkg::MAX_CHANNELS_DEF;
    localparam int FB = irb_pkg::FRAC_BITS_DEF;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] sample;
        logic [7:0] col;
        logic [7:0] row;
        logic [1:0] chan;
        logic       range_err;
    } pixel_result_t;

    typedef struct {
        logic       kind;
        logic [7:0] col;
        logic [7:0] row;
        logic [1:0] chan;
        logic [7:0] sample;
        bit         typed;      // expected value typed in below
        logic [7:0] want;
        logic       want_err;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [irb_pkg::CIDX_W-1:0] cfg_index = '0;
    logic [irb_pkg::CFG_W-1:0]  cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic m_tuser;

    always #5 clk = ~clk;

    image_resize_bilinear_nearest_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Shadow of the frame store and the register file
    logic [7:0] shadow_pixels [MW*MH*MC];
    bit         pixel_loaded  [MW*MH*MC];
    int unsigned src_w, src_h, dst_w, dst_h, chan_cnt;
    logic        mode;

    pixel_result_t pending_pixels[$];
    int errors = 0;
    int send_idle_pct = 0, recv_idle_pct = 0;
    int quiet_cycles = 0;

    function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return q;
    endfunction

    function automatic longint pin(longint v, int unsigned size);
        if (v < 0) return 0;
        if (v > longint'(size) - 1) return longint'(size) - 1;
        return v;
    endfunction

    // Map a target index to a source position with FB fraction bits
    function automatic longint src_pos(int unsigned d, int unsigned s, int unsigned t);
        longint num;
        num = (2 * longint'(d) + 1) * longint'(s) - longint'(t);
        return floor_quot(num * (longint'(1) << FB), 2 * longint'(t));
    endfunction

    function automatic longint nearest_idx(longint p);
        longint half, one;
        half = longint'(1) << (FB - 1);
        one  = longint'(1) << FB;
        if (p >= 0) return (p + half) / one;
        return -((-p + half) / one);
    endfunction

    function automatic longint unsigned px_at(longint x, longint y, int unsigned c);
        return shadow_pixels[(y * MW + x) * MC + c];
    endfunction

    function automatic pixel_result_t resample(logic [7:0] col, logic [7:0] row,
                                               logic [1:0] chan);
        pixel_result_t r;
        int unsigned sw, sh, tw, th, cc;
        longint px, py, one, lx, ly, x0, x1, y0, y1;
        longint unsigned fx, fy, gx, gy, acc, v;
        sw = eff_size(src_w, MW);
        sh = eff_size(src_h, MH);
        tw = eff_size(dst_w, 511);
        th = eff_size(dst_h, 511);
        cc = eff_size(chan_cnt, MC);
        r.col = col; r.row = row; r.chan = chan; r.sample = '0;
        r.range_err = (col >= tw) || (row >= th) || (chan >= cc);
        if (!r.range_err) begin
            px = src_pos(col, sw, tw);
            py = src_pos(row, sh, th);
            if (mode == irb_pkg::MODE_NEAREST) begin
                r.sample = px_at(pin(nearest_idx(px), sw), pin(nearest_idx(py), sh), chan);
            end else begin
                one = longint'(1) << FB;
                lx = floor_quot(px, one);
                ly = floor_quot(py, one);
                fx = px - lx * one; fy = py - ly * one;
                gx = one - fx;      gy = one - fy;
                x0 = pin(lx, sw); x1 = pin(lx + 1, sw);
                y0 = pin(ly, sh); y1 = pin(ly + 1, sh);
                acc = px_at(x0, y0, chan) * gx * gy + px_at(x1, y0, chan) * fx * gy
                    + px_at(x0, y1, chan) * gx * fy + px_at(x1, y1, chan) * fx * fy;
                v = (acc + (longint'(1) << (2 * FB - 1))) >> (2 * FB);
                r.sample = (v > 255) ? 8'd255 : v[7:0];
            end
        end
        return r;
    endfunction

    // Is every pixel the compute can touch already loaded? Avoid unwritten reads.
    function automatic bit footprint_loaded(logic [7:0] col, logic [7:0] row, logic [1:0] chan);
        int unsigned sw, sh, tw, th, cc;
        longint px, py, xs[2], ys[2];
        sw = eff_size(src_w, MW); sh = eff_size(src_h, MH);
        tw = eff_size(dst_w, 511); th = eff_size(dst_h, 511);
        cc = eff_size(chan_cnt, MC);
        if (col >= tw || row >= th || chan >= cc) return 1;
        px = src_pos(col, sw, tw); py = src_pos(row, sh, th);
        if (mode == irb_pkg::MODE_NEAREST) begin
            xs[0] = pin(nearest_idx(px), sw); xs[1] = xs[0];
            ys[0] = pin(nearest_idx(py), sh); ys[1] = ys[0];
        end else begin
            xs[0] = pin(px >>> FB, sw); xs[1] = pin((px >>> FB) + 1, sw);
            ys[0] = pin(py >>> FB, sh); ys[1] = pin((py >>> FB) + 1, sh);
        end
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                if (!pixel_loaded[(ys[j] * MW + xs[i]) * MC + chan]) return 0;
        return 1;
    endfunction

    task automatic write_reg(logic [irb_pkg::CIDX_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[irb_pkg::CFG_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            irb_pkg::REG_SRC_W: src_w    = val & 9'h1FF;
            irb_pkg::REG_SRC_H: src_h    = val & 9'h1FF;
            irb_pkg::REG_TGT_W: dst_w    = val & 9'h1FF;
            irb_pkg::REG_TGT_H: dst_h    = val & 9'h1FF;
            irb_pkg::REG_CHAN:  chan_cnt = val & 2'h3;
            irb_pkg::REG_MODE:  mode     = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned tw,
                                int unsigned th, int unsigned cc, logic md);
        write_reg(irb_pkg::REG_SRC_W, sw);
        write_reg(irb_pkg::REG_SRC_H, sh);
        write_reg(irb_pkg::REG_TGT_W, tw);
        write_reg(irb_pkg::REG_TGT_H, th);
        write_reg(irb_pkg::REG_CHAN, cc);
        write_reg(irb_pkg::REG_MODE, 32'(md));
    endtask

    // Send one request beat; queue the expected sample for computes
    task automatic send_req(logic kind, logic [7:0] col, logic [7:0] row,
                            logic [1:0] chan, logic [7:0] sample);
        pixel_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, sample, chan, row, col};
        do @(posedge clk); while (!s_tready);
        if (kind == irb_pkg::REQ_LOAD) begin
            if (chan < MC) begin
                shadow_pixels[(int'(row) * MW + col) * MC + chan] = sample;
                pixel_loaded[(int'(row) * MW + col) * MC + chan] = 1;
            end
        end else begin
            r = resample(col, row, chan);
            pending_pixels.push_back(r);
        end
    endtask

    task automatic drain_results();
        while (pending_pixels.size() != 0) @(posedge clk);
        // computes can finish after the last beat: let the divider settle
        repeat (100) @(posedge clk);
    endtask

    task automatic finish_send();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Random compute that only touches loaded pixels
    task automatic random_compute(int unsigned tw, int unsigned th);
        logic [7:0] c, r;
        logic [1:0] ch;
        int tries;
        tries = 0;
        do begin
            if ($urandom_range(9) == 0) begin
                c = 8'($urandom); r = 8'($urandom); ch = 2'($urandom);
            end else begin
                c = 8'($urandom_range(tw - 1)); r = 8'($urandom_range(th - 1));
                ch = 2'($urandom_range(eff_size(chan_cnt, MC) - 1));
            end
            tries++;
        end while (!footprint_loaded(c, r, ch) && tries < 50);
        if (footprint_loaded(c, r, ch))
            send_req(irb_pkg::REQ_COMPUTE, c, r, ch, 8'($urandom));
    endtask

    // Result checker and receiver stall
    always @(posedge clk) begin
        pixel_result_t got, want;
        if (m_tvalid && m_tready) begin
            got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[25:24], m_tuser};
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: stop if nothing moves for too long
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    stim_row_t directed[$];

    initial begin
        pixel_result_t r;
        src_w = 256; src_h = 256; dst_w = 256; dst_h = 256; chan_cnt = 3;
        mode = irb_pkg::MODE_BILINEAR;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: tiny 2x2 image, three channels, upscaled to 4x4
        set_geometry(2, 2, 4, 4, 3, irb_pkg::MODE_BILINEAR);
        directed = '{
            '{irb_pkg::REQ_LOAD, 8'd0, 8'd0, 2'd0, 8'd0,   0, 8'd0, 1'b0},
            '{irb_pkg::REQ_LOAD, 8'd1, 8'd0, 2'd0, 8'd255, 0, 8'd0, 1'b0},
            '{irb_pkg::REQ_LOAD, 8'd0, 8'd1, 2'd0, 8'd255, 0, 8'd0, 1'b0},
            '{irb_pkg::REQ_LOAD, 8'd1, 8'd1, 2'd0, 8'd0,   0, 8'd0, 1'b0},
            '{irb_pkg::REQ_LOAD, 8'd0, 8'd0, 2'd2, 8'd200, 0, 8'd0, 1'b0},
            '{irb_pkg::REQ_LOAD, 8'd1, 8'd0, 2'd2, 8'd200, 0, 8'd0, 1'b0},
            '{irb_pkg::REQ_LOAD, 8'd0, 8'd1, 2'd2, 8'd200, 0, 8'd0, 1'b0},
            '{irb_pkg::REQ_LOAD, 8'd1, 8'd1, 2'd2, 8'd200, 0, 8'd0, 1'b0},
            // load outside the store: dropped
            '{irb_pkg::REQ_LOAD, 8'd255, 8'd255, 2'd3, 8'd77, 0, 8'd0, 1'b0},
            '{irb_pkg::REQ_COMPUTE, 8'd0, 8'd0, 2'd0, 8'd0,   0, 8'd0, 1'b0},
            '{irb_pkg::REQ_COMPUTE, 8'd3, 8'd3, 2'd0, 8'd0,   0, 8'd0, 1'b0},
            '{irb_pkg::REQ_COMPUTE, 8'd1, 8'd2, 2'd0, 8'd0,   0, 8'd0, 1'b0},
            '{irb_pkg::REQ_COMPUTE, 8'd2, 8'd1, 2'd2, 8'd255, 1, 8'd200, 1'b0},
            // range errors: column, row, channel
            '{irb_pkg::REQ_COMPUTE, 8'd4, 8'd0, 2'd0, 8'd0,   1, 8'd0, 1'b1},
            '{irb_pkg::REQ_COMPUTE, 8'd0, 8'd255, 2'd0, 8'd0, 1, 8'd0, 1'b1},
            '{irb_pkg::REQ_COMPUTE, 8'd0, 8'd0, 2'd3, 8'd0,   1, 8'd0, 1'b1}
        };
        foreach (directed[i]) begin
            send_req(directed[i].kind, directed[i].col, directed[i].row,
                     directed[i].chan, directed[i].sample);
            if (directed[i].typed) begin
                r = pending_pixels[$];
                if (r.sample !== directed[i].want || r.range_err !== directed[i].want_err) begin
                    $display("%0t: table row %0d expected %0d/%0d actual %0d/%0d", $time, i,
                             directed[i].want, directed[i].want_err, r.sample, r.range_err);
                    errors++;
                end
            end
        end
        finish_send();
        drain_results();

        // Nearest mode on the same image, plus zero-size registers acting as one
        set_geometry(2, 2, 3, 3, 3, irb_pkg::MODE_NEAREST);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
                send_req(irb_pkg::REQ_COMPUTE, 8'(x), 8'(y), 2'd0, 8'hFF);
        finish_send();
        drain_results();
        set_geometry(0, 0, 0, 0, 0, irb_pkg::MODE_BILINEAR);
        send_req(irb_pkg::REQ_COMPUTE, 8'd0, 8'd0, 2'd0, 8'd0);
        send_req(irb_pkg::REQ_COMPUTE, 8'd1, 8'd0, 2'd0, 8'd0);
        finish_send();
        drain_results();

        // Random phases: load a source image, then mostly computes
        for (int ph = 0; ph < 6; ph++) begin
            int unsigned sw, sh, tw, th, cc;
            case (ph % 3)
                0: begin send_idle_pct = 20; recv_idle_pct = 82; end
                1: begin send_idle_pct = 82; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph == 5) begin
                sw = 256; sh = 1; tw = 256; th = 1; cc = 1;  // widest extreme
            end else if (ph == 4) begin
                sw = 1; sh = 1; tw = 200; th = 255; cc = 1;
            end else begin
                sw = $urandom_range(1, 8); sh = $urandom_range(1, 8);
                tw = $urandom_range(1, 24); th = $urandom_range(1, 24);
                cc = $urandom_range(1, 3);
            end
            set_geometry(sw, sh, tw, th, cc, ph[0]);
            for (int y = 0; y < sh; y++)
                for (int x = 0; x < sw; x++)
                    for (int c = 0; c < cc; c++)
                        if (ph != 5 || $urandom_range(3) == 0 || x < 4)
                            send_req(irb_pkg::REQ_LOAD, 8'(x), 8'(y), 2'(c), 8'($urandom));
            for (int n = 0; n < 75; n++) begin
                if ($urandom_range(9) == 0)
                    send_req(irb_pkg::REQ_LOAD, 8'($urandom), 8'($urandom),
                             2'($urandom_range(MC, 3)), 8'($urandom));
                else
                    random_compute(tw, th);
                if ($urandom_range(15) == 0) finish_send();
            end
            finish_send();
            drain_results();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ image_resize_bilinear_nearest_top.f @@
sv/irb_pkg.sv
sv/irb_div.sv
sv/image_resize_bilinear_nearest_top.sv
sv/irb_checker.sv
verif/image_resize_bilinear_nearest_top_test.sv
